>>> hdl/bdg_pkg.sv
`timescale 1ns / 1ps

package bdg_pkg;

  localparam int unsigned DbWidth   = 8;
  localparam int unsigned TimeWidth = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned EventW    = 3;

  localparam logic [DbWidth-1:0]   DebounceMaxRst = 8'd5;
  localparam logic [TimeWidth-1:0] LongPressRst   = 32'd1000;
  localparam logic [TimeWidth-1:0] DoubleClickRst = 32'd300;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE_MAX  = 3'd0,
    REG_EN_PRESS_DOWN = 3'd1,
    REG_EN_DCLICK     = 3'd2,
    REG_EN_DCLICK_HLD = 3'd3,
    REG_LONG_PRESS    = 3'd4,
    REG_DOUBLE_CLICK  = 3'd5
  } reg_idx_e;

  typedef enum logic [EventW-1:0] {
    EV_NONE         = 3'd0,
    EV_PRESS_DOWN   = 3'd1,
    EV_CLICK        = 3'd2,
    EV_DOUBLE_CLICK = 3'd3,
    EV_LONG_PRESS   = 3'd4,
    EV_LONG_RELEASE = 3'd5,
    EV_DCLICK_HOLD  = 3'd6
  } event_e;

  typedef struct packed {
    logic                 en_press_down;
    logic                 en_double_click;
    logic                 en_dclick_hold;
    logic [TimeWidth-1:0] long_press_ms;
    logic [TimeWidth-1:0] double_click_ms;
  } gest_cfg_t;

endpackage

>>> hdl/bdg_tick_if.sv
`timescale 1ns / 1ps

interface bdg_tick_if;
  logic        valid;
  logic        ready;
  logic        raw_pressed;
  logic [31:0] now_ms;

  modport source (output valid, output raw_pressed, output now_ms, input ready);
  modport sink   (input valid, input raw_pressed, input now_ms, output ready);
endinterface

>>> hdl/bdg_event_if.sv
`timescale 1ns / 1ps

interface bdg_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] gesture_event;

  modport source (output valid, output gesture_event, input ready);
  modport sink   (input valid, input gesture_event, output ready);
endinterface

>>> hdl/button_debounce_gesture_detector.sv
`timescale 1ns / 1ps
// channel    | dir | payload                         | accepted when
// tick_in    | in  | raw_pressed, now_ms             | tick_in.valid & tick_in.ready
// event_out  | out | gesture_event                   | event_out.valid & event_out.ready
// cfg        | in  | cfg_idx_i, cfg_data_i           | cfg_we_i
//
// one tick beat per cycle while event_out is ready; a tick goes via the tick and result registers
// the tick register and the result register each hold one beat, so one more tick is taken
// while a finished event waits for the consumer
// a stall on event_out backs up into the tick register, then drops tick_in.ready
// asynchronous active-low reset clears the pipeline, gesture state and loads register defaults

module button_debounce_gesture_detector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bdg_tick_if.sink                      tick_in,
  bdg_event_if.source                   event_out,
  input  logic                          cfg_we_i,
  input  logic [bdg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bdg_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bdg_pkg::*;

  logic [DbWidth-1:0]   debounce_max_q;
  gest_cfg_t            gcfg_q;

  logic                 tick_valid_q;
  logic                 raw_q;
  logic [TimeWidth-1:0] now_q;
  logic                 out_valid_q;
  event_e               event_q;

  logic                 tick_take;
  logic                 advance;
  logic                 stable, stable_prev;
  event_e               ev;

  assign advance        = tick_valid_q && (!out_valid_q || event_out.ready);
  assign tick_in.ready  = !tick_valid_q || advance;
  assign tick_take      = tick_in.valid && tick_in.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_max_q         <= DebounceMaxRst;
      gcfg_q.en_press_down   <= 1'b0;
      gcfg_q.en_double_click <= 1'b1;
      gcfg_q.en_dclick_hold  <= 1'b0;
      gcfg_q.long_press_ms   <= LongPressRst;
      gcfg_q.double_click_ms <= DoubleClickRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEBOUNCE_MAX:  debounce_max_q         <= cfg_data_i[DbWidth-1:0];
        REG_EN_PRESS_DOWN: gcfg_q.en_press_down   <= cfg_data_i[0];
        REG_EN_DCLICK:     gcfg_q.en_double_click <= cfg_data_i[0];
        REG_EN_DCLICK_HLD: gcfg_q.en_dclick_hold  <= cfg_data_i[0];
        REG_LONG_PRESS:    gcfg_q.long_press_ms   <= cfg_data_i[TimeWidth-1:0];
        REG_DOUBLE_CLICK:  gcfg_q.double_click_ms <= cfg_data_i[TimeWidth-1:0];
        default: ;
      endcase
    end
  end

  // tick register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_valid_q <= 1'b0;
    end else if (tick_take) begin
      tick_valid_q <= 1'b1;
    end else if (advance) begin
      tick_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_take) begin
      raw_q <= tick_in.raw_pressed;
      now_q <= tick_in.now_ms;
    end
  end

  bdg_debounce u_debounce (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (advance),
    .raw_i          (raw_q),
    .debounce_max_i (debounce_max_q),
    .stable_o       (stable),
    .stable_prev_o  (stable_prev)
  );

  bdg_gesture u_gesture (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .stable_i      (stable),
    .stable_prev_i (stable_prev),
    .now_i         (now_q),
    .cfg_i         (gcfg_q),
    .event_o       (ev)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (event_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) event_q <= ev;
  end

  assign event_out.valid         = out_valid_q;
  assign event_out.gesture_event = event_q;

  a_backpressure_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_valid_q && out_valid_q && !event_out.ready) |-> !tick_in.ready)
    else $error("tick taken while both stages are full");

endmodule

>>> hdl/bdg_debounce.sv
`timescale 1ns / 1ps

module bdg_debounce (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      raw_i,
  input  logic [bdg_pkg::DbWidth-1:0] debounce_max_i,
  output logic                      stable_o,
  output logic                      stable_prev_o
);
  import bdg_pkg::*;

  logic [DbWidth-1:0] count_q, count_d;
  logic [DbWidth-1:0] top;
  logic               stable_q, stable_d;

  always_comb begin
    top     = (debounce_max_i == '0) ? DbWidth'(1) : debounce_max_i;
    count_d = count_q;
    if (raw_i) begin
      if (count_q < top) count_d = count_q + DbWidth'(1);
    end else if (count_q != '0) begin
      count_d = count_q - DbWidth'(1);
    end
    if (count_d == top) begin
      stable_d = 1'b1;
    end else if (count_d == '0) begin
      stable_d = 1'b0;
    end else begin
      stable_d = stable_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      stable_q <= 1'b0;
    end else if (en_i) begin
      count_q  <= count_d;
      stable_q <= stable_d;
    end
  end

  assign stable_o      = stable_d;
  assign stable_prev_o = stable_q;

  a_stable_holds_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(en_i) |-> $stable(stable_q))
    else $error("stable level moved without a tick");

endmodule

>>> hdl/bdg_gesture.sv
`timescale 1ns / 1ps

module bdg_gesture (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          stable_i,
  input  logic                          stable_prev_i,
  input  logic [bdg_pkg::TimeWidth-1:0] now_i,
  input  bdg_pkg::gest_cfg_t            cfg_i,
  output bdg_pkg::event_e               event_o
);
  import bdg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE          = 3'd0,
    ST_PRESSED       = 3'd1,
    ST_WAIT_SECOND   = 3'd2,
    ST_WAIT_REL_LONG = 3'd3,
    ST_WAIT_REL_DC   = 3'd4,
    ST_WAIT_REL_HOLD = 3'd5
  } state_e;

  state_e               state_q, state_d;
  logic [TimeWidth-1:0] press_time_q, press_time_d;
  logic [TimeWidth-1:0] release_time_q, release_time_d;
  logic [TimeWidth-1:0] second_time_q, second_time_d;
  logic                 rise, fall;
  logic                 long_hit, dc_expired, hold_hit;
  event_e               ev;

  always_comb begin
    rise       = stable_i && !stable_prev_i;
    fall       = !stable_i && stable_prev_i;
    long_hit   = (now_i - press_time_q) >= cfg_i.long_press_ms;
    dc_expired = (now_i - release_time_q) >= cfg_i.double_click_ms;
    hold_hit   = (now_i - second_time_q) >= cfg_i.long_press_ms;

    state_d        = state_q;
    press_time_d   = press_time_q;
    release_time_d = release_time_q;
    second_time_d  = second_time_q;
    ev             = EV_NONE;

    case (state_q)
      ST_PRESSED: begin
        if (fall) begin
          if (cfg_i.en_double_click) begin
            state_d        = ST_WAIT_SECOND;
            release_time_d = now_i;
          end else begin
            state_d = ST_IDLE;
            ev      = EV_CLICK;
          end
        end else if (stable_i && long_hit) begin
          state_d = ST_WAIT_REL_LONG;
          ev      = EV_LONG_PRESS;
        end
      end
      ST_WAIT_SECOND: begin
        // pressed edge wins over the window timeout
        if (rise) begin
          state_d       = ST_WAIT_REL_DC;
          second_time_d = now_i;
          ev            = EV_DOUBLE_CLICK;
        end else if (dc_expired) begin
          state_d = ST_IDLE;
          ev      = EV_CLICK;
        end
      end
      ST_WAIT_REL_LONG: begin
        if (fall) begin
          state_d = ST_IDLE;
          ev      = EV_LONG_RELEASE;
        end
      end
      ST_WAIT_REL_DC: begin
        if (fall) begin
          state_d = ST_IDLE;
        end else if (cfg_i.en_dclick_hold && stable_i && hold_hit) begin
          state_d = ST_WAIT_REL_HOLD;
          ev      = EV_DCLICK_HOLD;
        end
      end
      ST_WAIT_REL_HOLD: begin
        if (fall) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
        if (rise) begin
          state_d      = ST_PRESSED;
          press_time_d = now_i;
          if (cfg_i.en_press_down) ev = EV_PRESS_DOWN;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      press_time_q   <= '0;
      release_time_q <= '0;
      second_time_q  <= '0;
    end else if (en_i) begin
      state_q        <= state_d;
      press_time_q   <= press_time_d;
      release_time_q <= release_time_d;
      second_time_q  <= second_time_d;
    end
  end

  assign event_o = ev;

  a_press_down_enters_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && ev == EV_PRESS_DOWN) |=> state_q == ST_PRESSED)
    else $error("press-down without entering pressed state");

  a_long_release_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && ev == EV_LONG_RELEASE) |=> state_q == ST_IDLE)
    else $error("long release did not return to idle");

  a_hold_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && ev == EV_DCLICK_HOLD) |-> cfg_i.en_dclick_hold)
    else $error("double-click hold reported while disabled");

endmodule

>>> sim/button_debounce_gesture_detector_test.sv
`timescale 1ns / 1ps

module button_debounce_gesture_detector_test;
  import bdg_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  typedef enum logic [2:0] {
    GS_IDLE          = 3'd0,
    GS_PRESSED       = 3'd1,
    GS_WAIT_SECOND   = 3'd2,
    GS_WAIT_REL_LONG = 3'd3,
    GS_WAIT_REL_DC   = 3'd4,
    GS_WAIT_REL_HOLD = 3'd5
  } gest_state_e;

  typedef struct packed {
    logic                 raw;
    logic [TimeWidth-1:0] now;
  } tick_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  bdg_tick_if  tick_if ();
  bdg_event_if event_if ();

  button_debounce_gesture_detector u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_in    (tick_if),
    .event_out  (event_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // register copies
  logic [DbWidth-1:0]   cfg_db_max      = DebounceMaxRst;
  logic                 cfg_press_down  = 1'b0;
  logic                 cfg_dclick      = 1'b1;
  logic                 cfg_dclick_hold = 1'b0;
  logic [TimeWidth-1:0] cfg_long_ms     = LongPressRst;
  logic [TimeWidth-1:0] cfg_dclick_ms   = DoubleClickRst;

  // debounce and gesture state
  logic [DbWidth-1:0]   integ     = '0;
  logic                 level     = 1'b0;
  logic                 level_q   = 1'b0;
  gest_state_e          gstate    = GS_IDLE;
  logic [TimeWidth-1:0] press_at  = '0;
  logic [TimeWidth-1:0] release_at = '0;
  logic [TimeWidth-1:0] second_at = '0;

  tick_t                pending_ticks[$];
  event_e               expected_events[$];
  logic [TimeWidth-1:0] clock_ms = '0;
  int unsigned          ticks_queued = 0;
  int unsigned          ticks_taken = 0;
  int unsigned          settings_count = 0;
  int unsigned          mismatch_count = 0;
  int unsigned          cycle_count = 0;
  int unsigned          event_tally [8];
  int unsigned          ms_step = 25;

  int unsigned          tick_wait;
  logic                 tick_calm = 1'b0;
  tick_t                next_tick;
  int unsigned          event_stall;
  int unsigned          stall_next;
  logic                 event_calm = 1'b0;
  event_e               want;

  function automatic event_e gesture_predict(input logic raw, input logic [TimeWidth-1:0] now);
    logic [DbWidth-1:0]   top;
    logic [TimeWidth-1:0] held;
    logic                 rise;
    logic                 fall;
    event_e               ev;
    top = (cfg_db_max == '0) ? 8'd1 : cfg_db_max;
    ev = EV_NONE;
    if (raw) begin
      if (integ < top) integ = integ + 8'd1;
    end else if (integ != '0) begin
      integ = integ - 8'd1;
    end
    if (integ == top) level = 1'b1;
    else if (integ == '0) level = 1'b0;
    rise = level & ~level_q;
    fall = ~level & level_q;
    case (gstate)
      GS_PRESSED: begin
        held = now - press_at;
        if (fall) begin
          if (cfg_dclick) begin
            gstate = GS_WAIT_SECOND;
            release_at = now;
          end else begin
            gstate = GS_IDLE;
            ev = EV_CLICK;
          end
        end else if (level && held >= cfg_long_ms) begin
          gstate = GS_WAIT_REL_LONG;
          ev = EV_LONG_PRESS;
        end
      end
      GS_WAIT_SECOND: begin
        held = now - release_at;
        // a new press wins over the window running out
        if (rise) begin
          gstate = GS_WAIT_REL_DC;
          second_at = now;
          ev = EV_DOUBLE_CLICK;
        end else if (held >= cfg_dclick_ms) begin
          gstate = GS_IDLE;
          ev = EV_CLICK;
        end
      end
      GS_WAIT_REL_LONG: begin
        if (fall) begin
          gstate = GS_IDLE;
          ev = EV_LONG_RELEASE;
        end
      end
      GS_WAIT_REL_DC: begin
        held = now - second_at;
        if (fall) begin
          gstate = GS_IDLE;
        end else if (cfg_dclick_hold && level && held >= cfg_long_ms) begin
          gstate = GS_WAIT_REL_HOLD;
          ev = EV_DCLICK_HOLD;
        end
      end
      GS_WAIT_REL_HOLD: begin
        if (fall) gstate = GS_IDLE;
      end
      default: begin
        gstate = GS_IDLE;
        if (rise) begin
          gstate = GS_PRESSED;
          press_at = now;
          if (cfg_press_down) ev = EV_PRESS_DOWN;
        end
      end
    endcase
    level_q = level;
    return ev;
  endfunction

  // tick driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_if.valid       <= 1'b0;
      tick_if.raw_pressed <= 1'b0;
      tick_if.now_ms      <= '0;
      tick_wait           <= 0;
    end else begin
      if (tick_if.valid && tick_if.ready) begin
        expected_events.push_back(gesture_predict(tick_if.raw_pressed, tick_if.now_ms));
        ticks_taken++;
      end
      if (!tick_if.valid || tick_if.ready) begin
        if (tick_wait != 0) begin
          tick_wait     <= tick_wait - 1;
          tick_if.valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          next_tick = pending_ticks.pop_front();
          tick_if.valid       <= 1'b1;
          tick_if.raw_pressed <= next_tick.raw;
          tick_if.now_ms      <= next_tick.now;
          if ($urandom_range(0, 31) == 0) tick_calm = ~tick_calm;
          tick_wait <= tick_calm ? 0 : $urandom_range(0, 9);
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  // event monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_if.ready <= 1'b0;
      event_stall    <= 0;
    end else begin
      stall_next = event_stall;
      if (event_if.valid && event_if.ready) begin
        event_tally[event_if.gesture_event]++;
        if (expected_events.size() == 0) begin
          $error("gesture_event: beat with nothing expected, actual %0d",
                 event_if.gesture_event);
          mismatch_count++;
        end else begin
          want = expected_events.pop_front();
          if (event_if.gesture_event !== want) begin
            $error("gesture_event: expected %0d (%s), actual %0d",
                   want, want.name(), event_if.gesture_event);
            mismatch_count++;
          end
        end
        if ($urandom_range(0, 31) == 0) event_calm = ~event_calm;
        stall_next = event_calm ? 0 : $urandom_range(0, 9);
      end else if (stall_next != 0) begin
        stall_next = stall_next - 1;
      end
      event_stall    <= stall_next;
      event_if.ready <= (stall_next == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_DEBOUNCE_MAX:  cfg_db_max      = data[DbWidth-1:0];
      REG_EN_PRESS_DOWN: cfg_press_down  = data[0];
      REG_EN_DCLICK:     cfg_dclick      = data[0];
      REG_EN_DCLICK_HLD: cfg_dclick_hold = data[0];
      REG_LONG_PRESS:    cfg_long_ms     = data;
      REG_DOUBLE_CLICK:  cfg_dclick_ms   = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // upper bits are random so masking gets exercised
  task automatic apply_settings(input logic [7:0] db, input logic pd, input logic dc,
                                input logic hold, input logic [31:0] long_ms,
                                input logic [31:0] dc_ms);
    logic [31:0] rnd;
    rnd = $urandom();
    write_reg(REG_DEBOUNCE_MAX, {rnd[31:8], db});
    rnd = $urandom();
    write_reg(REG_EN_PRESS_DOWN, {rnd[31:1], pd});
    rnd = $urandom();
    write_reg(REG_EN_DCLICK, {rnd[31:1], dc});
    rnd = $urandom();
    write_reg(REG_EN_DCLICK_HLD, {rnd[31:1], hold});
    write_reg(REG_LONG_PRESS, long_ms);
    write_reg(REG_DOUBLE_CLICK, dc_ms);
    write_reg(settings_count[0] ? RegSpareHi : RegSpareLo, $urandom());
    settings_count++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_ticks.size() != 0 || tick_if.valid || expected_events.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic push_at(input logic raw, input logic [31:0] t);
    clock_ms = t;
    pending_ticks.push_back('{raw: raw, now: t});
    ticks_queued++;
  endtask

  task automatic push_tick(input logic raw, input int unsigned step);
    push_at(raw, clock_ms + step);
  endtask

  // mostly steady level with the odd bounce
  task automatic hold_level(input logic lvl, input int unsigned count, input int unsigned step);
    for (int unsigned i = 0; i < count; i++)
      push_tick(($urandom_range(0, 15) == 0) ? ~lvl : lvl, $urandom_range(0, step));
  endtask

  task automatic gesture_phase(input int unsigned n, input logic tail_level);
    int unsigned goal;
    int unsigned top;
    goal = ticks_queued + n;
    top = (cfg_db_max == '0) ? 1 : cfg_db_max;
    while (ticks_queued < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          hold_level(1'b1, top + $urandom_range(0, 4), ms_step);
          hold_level(1'b0, top + $urandom_range(0, 4), ms_step);
          if ($urandom_range(0, 1)) hold_level(1'b0, $urandom_range(1, 4), 4 * ms_step);
        end
        3, 4: begin
          hold_level(1'b1, top + $urandom_range(0, 3), ms_step);
          hold_level(1'b0, top + $urandom_range(0, 3), ms_step / 2);
          hold_level(1'b1, top + $urandom_range(0, 6), 2 * ms_step);
          hold_level(1'b0, top + $urandom_range(0, 3), ms_step);
        end
        5, 6: begin
          hold_level(1'b1, top + $urandom_range(2, 12), 4 * ms_step);
          hold_level(1'b0, top + $urandom_range(0, 3), ms_step);
        end
        7: begin
          repeat ($urandom_range(4, 12))
            push_tick(1'($urandom_range(0, 1)), $urandom_range(0, ms_step));
        end
        8: hold_level(1'b0, $urandom_range(2, 8), 4 * ms_step);
        default: begin
          repeat ($urandom_range(2, 4)) push_tick(1'($urandom_range(0, 1)), $urandom());
        end
      endcase
    end
    hold_level(tail_level, top + 2, ms_step);
  endtask

  initial begin
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= '0;
    cfg_data_i          <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // zero debounce max acts as one, so the stable level follows raw
    apply_settings(8'd0, 1'b1, 1'b1, 1'b1, 32'd100, 32'd50);
    push_at(1'b0, 32'd0);
    push_at(1'b1, 32'd10);
    push_at(1'b0, 32'd20);
    push_at(1'b1, 32'd70);
    push_at(1'b1, 32'd170);
    push_at(1'b0, 32'd180);
    push_at(1'b1, 32'd200);
    push_at(1'b1, 32'd300);
    push_at(1'b0, 32'd310);
    push_at(1'b1, 32'd320);
    push_at(1'b0, 32'd330);
    push_at(1'b0, 32'd380);
    push_at(1'b1, 32'hFFFF_FFF0);
    push_at(1'b1, 32'h0000_0050);
    push_at(1'b1, 32'h0000_0054);
    push_at(1'b0, 32'hFFFF_FFFF);
    push_at(1'b0, 32'd0);
    wait_drained();

    // zero windows, double click off
    apply_settings(8'd1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0);
    push_tick(1'b1, 5);
    push_tick(1'b1, 0);
    push_tick(1'b0, 5);
    push_tick(1'b1, 5);
    push_tick(1'b0, 5);
    wait_drained();

    apply_settings(8'd2, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'd0);
    push_tick(1'b1, 3);
    push_tick(1'b1, 3);
    push_tick(1'b0, 3);
    push_tick(1'b0, 3);
    push_tick(1'b0, 0);
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        3: apply_settings(8'd48, 1'b1, 1'b1, 1'b1, 32'd400, 32'd100);
        // below the count left by the previous phase's held tail
        4: apply_settings(8'd20, 1'b1, 1'b1, 1'b1, 32'd0, 32'd0);
        6: apply_settings(8'($urandom_range(1, 6)), 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF);
        default: apply_settings(8'($urandom_range(1, 6)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                $urandom_range(0, 250), $urandom_range(0, 120));
      endcase
      gesture_phase((ph == 3 || ph == 4) ? 150 : 130, (ph == 3) ? 1'b1 : ph[0]);
      wait_drained();
    end

    $display("%0d ticks over %0d register settings, events seen: none %0d, press-down %0d,",
             ticks_taken, settings_count, event_tally[0], event_tally[1]);
    $display("click %0d, double-click %0d, long-press %0d, long-release %0d, dclick-hold %0d",
             event_tally[2], event_tally[3], event_tally[4], event_tally[5], event_tally[6]);
    if (mismatch_count == 0 && expected_events.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
